FILE: sv/multi_voice_pcm_mixer_assert.svh
// Assertion macros for the PCM mixer checkers.
// Depends on signals clk and rst in the including scope.
`ifndef MULTI_VOICE_PCM_MIXER_ASSERT_SVH
`define MULTI_VOICE_PCM_MIXER_ASSERT_SVH

// check a property while out of reset
`define MVPM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property at every edge, reset included
`define MVPM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/mvpm_pkg.sv
// Shared types and constants of the PCM mixer.
// No dependencies.
package mvpm_pkg;

  localparam int VOICES     = 8;
  localparam int VOICE_W    = $clog2(VOICES);
  localparam int MEM_AW     = 16;
  localparam int MAX_CHUNK  = 64;
  localparam int FRAME_W    = $clog2(MAX_CHUNK);
  localparam int HANDLE_MIN = 100;
  localparam int RECIP_127  = 33027;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_RENDER = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {OP_LOAD, OP_START, OP_RENDER} op_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] mem_address;
    logic [7:0]  mem_byte;
    logic [15:0] sample_start;
    logic [15:0] sample_length;
    logic [6:0]  gain_in;
    logic [7:0]  pan;
    logic [23:0] pitch_step;
    logic [30:0] now_tick;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               last_frame;
    logic [15:0]        voice_handle;
    logic [2:0]         voice_slot;
  } out_item_t;

  typedef struct packed {
    op_t      op;
    in_item_t data;
  } q_item_t;

endpackage

FILE: sv/mvpm_front.sv
// Front end: accepts input words, classifies the command, queues work.
// Depends on mvpm_pkg.
module mvpm_front import mvpm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  input  logic     q_ready,
  output q_item_t  q_item
);

  q_item_t    ent [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       keep;
  logic       push;
  logic       pop;
  op_t        op;

  always_comb begin
    op   = OP_LOAD;
    keep = 1'b1;
    unique case (in_data.command)
      CMD_LOAD:   op = OP_LOAD;
      CMD_START:  op = OP_START;
      CMD_RENDER: op = OP_RENDER;
      default:    keep = 1'b0;
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= '{op: op, data: in_data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: sv/mvpm_back.sv
// Back end: sample memory, voice state, start and render sequencing, output register.
// Depends on mvpm_pkg.
module mvpm_back import mvpm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic [6:0] frames_cfg,
  input  logic      q_valid,
  output logic      q_ready,
  input  q_item_t   q_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_MUL, ST_GAIN, ST_ISSUE, ST_DRAIN, ST_EMIT
  } state_t;

  state_t state;
  in_item_t cur;
  logic [VOICE_W-1:0] vcnt;
  logic [FRAME_W-1:0] frame;
  logic [1:0] drain;
  logic found_free;
  logic [VOICE_W-1:0] sel_slot;
  logic [30:0] oldest;
  logic [16:0] sql, sqr;
  logic [23:0] pl, pr;
  logic [15:0] handle_counter;

  logic        v_active [VOICES];
  logic [15:0] v_base   [VOICES];
  logic [15:0] v_len    [VOICES];
  logic [16:0] v_pos    [VOICES];
  logic [15:0] v_frac   [VOICES];
  logic [23:0] v_step   [VOICES];
  logic [30:0] v_tick   [VOICES];
  logic [6:0]  v_lg     [VOICES];
  logic [6:0]  v_rg     [VOICES];
  logic [31:0] v_budget [VOICES];

  logic [7:0] mem [2**MEM_AW];
  logic [7:0] mem_rd;
  logic       mem_we;
  logic [MEM_AW-1:0] rd_addr;

  logic p1_valid;
  logic [6:0] p1_lg, p1_rg;
  logic p2_valid, p2_neg;
  logic [13:0] p2_ml, p2_mr;
  logic signed [19:0] acc_l, acc_r;

  logic [6:0] frames_eff;
  logic [15:0] rem;
  logic [31:0] bud;
  logic play;
  logic [24:0] fsum;
  logic [7:0] mag;
  logic neg;
  logic [14:0] yl, yr;
  logic [30:0] tl, tr;
  logic [15:0] ql, qr;
  logic [7:0] gl, gr;
  logic [15:0] hc;
  logic out_free;
  logic out_load;
  logic last;

  function automatic logic [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) return 16'h7fff;
    else if (v < -20'sd32768) return 16'h8000;
    else return v[15:0];
  endfunction

  assign frames_eff = (frames_cfg == 7'd0) ? 7'd1 :
                      (frames_cfg > 7'(MAX_CHUNK)) ? 7'(MAX_CHUNK) : frames_cfg;
  assign q_ready  = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign out_load = ((state == ST_GAIN) || (state == ST_EMIT)) && out_free;
  assign mem_we   = (state == ST_IDLE) && q_valid && (q_item.op == OP_LOAD);
  assign last     = ({1'b0, frame} + 7'd1 == frames_eff);

  always_comb begin
    rem  = ({1'b0, v_len[vcnt]} > v_pos[vcnt]) ? v_len[vcnt] - v_pos[vcnt][15:0] : 16'd0;
    bud  = (frame == '0) ? {rem, 16'h0} : v_budget[vcnt];
    play = v_active[vcnt] && ((v_step[vcnt] == 24'd0) || ({8'd0, v_step[vcnt]} <= bud));
    fsum = {9'd0, v_frac[vcnt]} + {1'b0, v_step[vcnt]};
    rd_addr = v_base[vcnt] + v_pos[vcnt][15:0];
    neg  = mem_rd < 8'd128;
    mag  = neg ? 8'd128 - mem_rd : mem_rd - 8'd128;
    yl   = {p2_ml, 1'b0};
    yr   = {p2_mr, 1'b0};
    tl   = 31'(yl) * 31'(RECIP_127);
    tr   = 31'(yr) * 31'(RECIP_127);
    ql   = 16'(yl) + 16'(tl[30:22]);
    qr   = 16'(yr) + 16'(tr[30:22]);
    gl   = {1'b0, cur.gain_in} - pl[23:16];
    gr   = {1'b0, cur.gain_in} - pr[23:16];
    hc   = (handle_counter == 16'd0) ? 16'(HANDLE_MIN) : handle_counter;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[q_item.data.mem_address] <= q_item.data.mem_byte;
    mem_rd <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    p1_lg <= v_lg[vcnt];
    p1_rg <= v_rg[vcnt];
    p2_ml <= 14'(p1_lg * mag);
    p2_mr <= 14'(p1_rg * mag);
    p2_neg <= neg;
    sql <= 17'(({1'b0, cur.pan} + 9'd1) * ({1'b0, cur.pan} + 9'd1));
    sqr <= 17'((9'd256 - {1'b0, cur.pan}) * (9'd256 - {1'b0, cur.pan}));
    pl <= 24'(cur.gain_in * sql);
    pr <= 24'(cur.gain_in * sqr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      acc_l <= '0;
      acc_r <= '0;
      handle_counter <= 16'd0;
      vcnt <= '0;
      frame <= '0;
      drain <= '0;
      for (int i = 0; i < VOICES; i++) begin
        v_active[i] <= 1'b0;
        v_base[i] <= '0;
        v_len[i] <= '0;
        v_pos[i] <= '0;
        v_frac[i] <= '0;
        v_step[i] <= '0;
        v_tick[i] <= '0;
        v_lg[i] <= '0;
        v_rg[i] <= '0;
        v_budget[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready && !out_load) out_valid <= 1'b0;
      p1_valid <= (state == ST_ISSUE) && play;
      p2_valid <= p1_valid;
      if (p2_valid) begin
        acc_l <= p2_neg ? acc_l - 20'(ql) : acc_l + 20'(ql);
        acc_r <= p2_neg ? acc_r - 20'(qr) : acc_r + 20'(qr);
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur <= q_item.data;
            vcnt <= '0;
            frame <= '0;
            found_free <= 1'b0;
            sel_slot <= '0;
            oldest <= q_item.data.now_tick;
            if (q_item.op == OP_START) state <= ST_SCAN;
            else if (q_item.op == OP_RENDER) state <= ST_ISSUE;
          end
        end
        ST_SCAN: begin
          if (!found_free) begin
            if (!v_active[vcnt]) begin
              found_free <= 1'b1;
              sel_slot <= vcnt;
            end else if (v_tick[vcnt] < oldest) begin
              oldest <= v_tick[vcnt];
              sel_slot <= vcnt;
            end
          end
          vcnt <= vcnt + 1'b1;
          if (vcnt == VOICE_W'(VOICES - 1)) state <= ST_MUL;
        end
        ST_MUL: state <= ST_GAIN;
        ST_GAIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data <= '{left_out: '0, right_out: '0, last_frame: 1'b1,
                          voice_handle: hc, voice_slot: 3'(sel_slot)};
            handle_counter <= hc + 16'd1;
            v_active[sel_slot] <= 1'b1;
            v_base[sel_slot] <= cur.sample_start;
            v_len[sel_slot] <= cur.sample_length;
            v_pos[sel_slot] <= '0;
            v_frac[sel_slot] <= '0;
            v_step[sel_slot] <= cur.pitch_step;
            v_tick[sel_slot] <= cur.now_tick;
            v_lg[sel_slot] <= gl[6:0];
            v_rg[sel_slot] <= gr[6:0];
            state <= ST_IDLE;
          end
        end
        ST_ISSUE: begin
          if (play) begin
            v_pos[vcnt] <= v_pos[vcnt] + {8'd0, fsum[24:16]};
            v_frac[vcnt] <= fsum[15:0];
            v_budget[vcnt] <= bud - {8'd0, v_step[vcnt]};
          end else if (v_active[vcnt]) begin
            v_active[vcnt] <= 1'b0;
          end
          vcnt <= vcnt + 1'b1;
          drain <= '0;
          if (vcnt == VOICE_W'(VOICES - 1)) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          drain <= drain + 2'd1;
          if (drain == 2'd2) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data <= '{left_out: sat16(acc_l), right_out: sat16(acc_r),
                          last_frame: last, voice_handle: '0, voice_slot: '0};
            acc_l <= '0;
            acc_r <= '0;
            vcnt <= '0;
            frame <= frame + 1'b1;
            state <= last ? ST_IDLE : ST_ISSUE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/multi_voice_pcm_mixer.sv
// Top level of the eight-voice PCM mixer: configuration register, front end, back end.
// Depends on mvpm_pkg, mvpm_front, mvpm_back.
//
//   channel | signals                     | direction
//   in      | in_valid in_ready in_data   | word in
//   out     | out_valid out_ready out_data| word out
//   cfg     | cfg_we cfg_data             | frames_per_chunk write
//
// A load writes one memory byte; a start does a slot scan over all voices and the gain multiplies.
// A render issues each voice, then drains the pipeline and emits, once per frame,
// for up to 64 frames a chunk.
// Reset is synchronous and clears all voices; sample memory is not cleared.
// A stalled output holds the back end; the input queue holds two words.
module multi_voice_pcm_mixer import mvpm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [6:0] cfg_data
);

  logic [6:0] frames_per_chunk;
  logic       q_valid;
  logic       q_ready;
  q_item_t    q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_per_chunk <= 7'(MAX_CHUNK);
    end else if (cfg_we) begin
      frames_per_chunk <= cfg_data;
    end
  end

  mvpm_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  mvpm_back u_back (
    .clk(clk), .rst(rst), .frames_cfg(frames_per_chunk),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

FILE: sv/mvpm_checker.sv
// Port-level checks of the PCM mixer, bound to the top level.
// Depends on mvpm_pkg and multi_voice_pcm_mixer_assert.svh.
`include "multi_voice_pcm_mixer_assert.svh"
module mvpm_port_checker import mvpm_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  logic stalled;
  logic start_word;
  logic start_blank;
  logic handle_ok;

  assign stalled     = out_valid && !out_ready;
  assign start_word  = out_valid && (out_data.voice_handle != 16'd0);
  assign start_blank = (out_data.left_out == 16'sd0) && (out_data.right_out == 16'sd0) &&
                       out_data.last_frame;
  assign handle_ok   = out_data.voice_handle >= 16'(HANDLE_MIN);

  `MVPM_ASSERT(a_out_hold, stalled |=> out_valid && $stable(out_data), "word changed while stalled")
  `MVPM_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid, "output valid after reset")
  `MVPM_ASSERT(a_start_word, start_word |-> start_blank, "start word malformed")
  `MVPM_ASSERT(a_handle_range, start_word |-> handle_ok, "handle below minimum")

endmodule

bind multi_voice_pcm_mixer mvpm_port_checker u_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

FILE: tb/mvpm_checker.sv
// Scoreboard for the PCM mixer: watches the in and out channels, predicts each result word.
// Depends on mvpm_pkg; frames_per_chunk arrives through the cfg write port signals.
module mvpm_checker import mvpm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  mem [0:65535];
  logic        act [VOICES];
  logic [15:0] base [VOICES];
  logic [15:0] len [VOICES];
  logic [16:0] pos [VOICES];
  logic [15:0] frac [VOICES];
  logic [23:0] step [VOICES];
  logic [30:0] tick [VOICES];
  logic [6:0]  lgain [VOICES];
  logic [6:0]  rgain [VOICES];
  logic [15:0] handle_ctr;
  logic [6:0]  chunk_reg;
  out_item_t   expected_words [$];

  function automatic int pan_gain(int vol, int s);
    int g;
    g = vol - ((vol * s * s) >>> 16);
    if (g < 0) g = 0;
    if (g > 127) g = 127;
    return g;
  endfunction

  function automatic int scale(int g, int b);
    return (g * (b - 128) * 256) / 127;
  endfunction

  function automatic logic [15:0] sat16(int v);
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic predict_mix(input in_item_t w);
    int slot, oldest, i, frames, n, lg, rg, s;
    int accl [MAX_CHUNK];
    int accr [MAX_CHUNK];
    logic [31:0] rem, fr;
    logic [16:0] p;
    longint lim;
    bit ends;
    out_item_t o;
    case (w.command)
      CMD_LOAD: mem[w.mem_address] = w.mem_byte;
      CMD_START: begin
        oldest = w.now_tick;
        slot = 0;
        for (i = 0; i < VOICES && act[i]; i++) begin
          if (int'(tick[i]) < oldest) begin
            oldest = tick[i];
            slot = i;
          end
        end
        if (i < VOICES) slot = i;
        s = int'(w.pan) + 1;
        lg = pan_gain(w.gain_in, s);
        rg = pan_gain(w.gain_in, s - 257);
        if (handle_ctr == 16'd0) handle_ctr = 16'(HANDLE_MIN);
        o = '0;
        o.last_frame = 1'b1;
        o.voice_handle = handle_ctr;
        o.voice_slot = 3'(slot);
        handle_ctr = handle_ctr + 16'd1;
        act[slot] = 1'b1;
        base[slot] = w.sample_start;
        len[slot] = w.sample_length;
        pos[slot] = '0;
        frac[slot] = '0;
        step[slot] = w.pitch_step;
        tick[slot] = w.now_tick;
        lgain[slot] = 7'(lg);
        rgain[slot] = 7'(rg);
        expected_words.push_back(o);
      end
      CMD_RENDER: begin
        frames = chunk_reg;
        if (frames == 0) frames = 1;
        if (frames > MAX_CHUNK) frames = MAX_CHUNK;
        for (i = 0; i < MAX_CHUNK; i++) begin
          accl[i] = 0;
          accr[i] = 0;
        end
        for (int v = 0; v < VOICES; v++) begin
          if (!act[v]) continue;
          p = pos[v];
          fr = frac[v];
          rem = (len[v] > p) ? len[v] - p : 0;
          n = frames;
          ends = 0;
          if (step[v] != 0) begin
            lim = (longint'(rem) << 16) / step[v];
            if (lim < frames) begin
              n = int'(lim);
              ends = 1;
            end
          end
          for (int f = 0; f < n; f++) begin
            accl[f] += scale(lgain[v], mem[base[v] + p[15:0]]);
            accr[f] += scale(rgain[v], mem[base[v] + p[15:0]]);
            fr = fr + step[v];
            p = p + fr[31:16];
            fr = fr & 32'hffff;
          end
          if (ends) act[v] = 1'b0;
          pos[v] = p;
          frac[v] = fr[15:0];
        end
        for (int f = 0; f < frames; f++) begin
          o = '0;
          o.left_out = sat16(accl[f]);
          o.right_out = sat16(accr[f]);
          o.last_frame = (f + 1 == frames);
          expected_words.push_back(o);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      for (int v = 0; v < VOICES; v++) begin
        act[v] = 0; base[v] = 0; len[v] = 0; pos[v] = 0; frac[v] = 0;
        step[v] = 0; tick[v] = 0; lgain[v] = 0; rgain[v] = 0;
      end
      handle_ctr = 0;
      chunk_reg = 7'(MAX_CHUNK);
      expected_words.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) chunk_reg = cfg_data;
      if (in_valid && in_ready) predict_mix(in_data);
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          if (fail_count < 10) $display("unexpected word %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_words.pop_front();
          if (e !== out_data) begin
            if (fail_count < 10) $display("mismatch: expected %p actual %p", e, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_words.size();
    end
  end
endmodule

FILE: tb/multi_voice_pcm_mixer_tb.sv
// Top of the PCM mixer testbench: clock, reset, stimulus, verdict.
// Depends on mvpm_pkg, mvpm_checker and the multi_voice_pcm_mixer RTL.
module multi_voice_pcm_mixer_tb import mvpm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0, cfg_we = 0;
  logic [6:0] cfg_data = '0;
  in_item_t in_data = '0;
  out_item_t out_data;
  int fail_count, pending, cycles = 0;
  bit written [logic [15:0]];
  logic [15:0] loaded [$];

  always #5 clk = ~clk;

  multi_voice_pcm_mixer dut (.*);
  mvpm_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : sink
    int w;
    forever begin
      w = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) w = 0;
      repeat (w) @(posedge clk);
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
      out_ready <= 0;
    end
  end

  task automatic send(input in_item_t w);
    repeat ($urandom_range(0, 7)) @(posedge clk);
    in_valid <= 1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    in_valid <= 0;
    if (w.command == CMD_LOAD) begin
      if (!written.exists(w.mem_address)) loaded.push_back(w.mem_address);
      written[w.mem_address] = 1;
    end
  endtask

  task automatic load(input logic [15:0] a, input logic [7:0] b);
    in_item_t w;
    w = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    w.command = CMD_LOAD;
    w.mem_address = a;
    w.mem_byte = b;
    send(w);
  endtask

  // start within a loaded region (length 0 or 1 keeps reads inside it)
  task automatic start_voice(input logic [15:0] st, input logic [15:0] ln,
                             input logic [6:0] g, input logic [7:0] pn,
                             input logic [23:0] stp, input logic [30:0] tk);
    in_item_t w;
    w = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    w.command = CMD_START;
    w.sample_start = st;
    w.sample_length = ln;
    w.gain_in = g;
    w.pan = pn;
    w.pitch_step = stp;
    w.now_tick = tk;
    send(w);
  endtask

  task automatic render();
    in_item_t w;
    w = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    w.command = CMD_RENDER;
    send(w);
  endtask

  task automatic set_chunk(input logic [6:0] n);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (800) @(posedge clk);
    cfg_we <= 1;
    cfg_data <= n;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  initial begin : stim
    in_item_t w;
    logic [15:0] a;
    int ln;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    set_chunk(7'd64);
    for (int i = 0; i < 40; i++)
      load(16'hfff0 + 16'(i), i == 0 ? 8'h00 : (i == 1 ? 8'hff : 8'($urandom)));
    start_voice(16'hfff0, 16'd20, 7'd127, 8'd0, 24'h010000, 31'd5);
    start_voice(16'hfff0, 16'd30, 7'd127, 8'd255, 24'h008000, 31'd0);
    start_voice(16'hfff1, 16'd10, 7'd0, 8'd128, 24'hffffff, 31'h7fffffff);
    start_voice(16'hfff0, 16'd1, 7'd127, 8'd127, 24'd0, 31'd3);
    render();
    w = '0;
    w.command = CMD_UNUSED;
    send(w);
    for (int i = 0; i < 5; i++) start_voice(16'hfff0, 16'd1, 7'd127, 8'd0, 24'd0, 31'(i));
    start_voice(16'hfff0, 16'd0, 7'd127, 8'd255, 24'h020000, 31'd2);
    start_voice(16'hfff0, 16'd0, 7'd127, 8'd255, 24'h020000, 31'd0);
    render();
    set_chunk(7'd1);
    render();
    set_chunk(7'd0);
    render();
    set_chunk(7'd127);
    render();
    for (int ph = 0; ph < 4; ph++) begin
      set_chunk(ph == 0 ? 7'd64 : 7'($urandom_range(1, 16)));
      for (int i = 0; i < 10; i++) begin
        case ($urandom_range(0, 5))
          0, 1: begin
            a = 16'($urandom);
            load(a, 8'($urandom));
          end
          2, 3: begin
            a = loaded[$urandom_range(0, loaded.size() - 1)];
            ln = 0;
            while (ln < 300 && written.exists(a + ln[15:0] + 16'd1)) ln++;
            start_voice(a, ln[15:0], 7'($urandom), 8'($urandom),
                        $urandom_range(0, 3) == 0 ? 24'd0 : 24'($urandom_range(1, 24'h030000)),
                        31'($urandom));
          end
          default: render();
        endcase
        if (ph == 3 && i == 9) begin
          for (int k = 0; k < 8; k++) start_voice(16'hfff0, 16'd0, 7'($urandom), 8'($urandom),
                                                  24'h010000, 31'd0);
          render();
        end
      end
    end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
